// ----- rtl/core/irta_pkg.sv -----
package irta_pkg;

   // Field widths
   localparam int MODE_W  = 2;
   localparam int VALUE_W = 64;
   localparam int RADIX_W = 5;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 6;

   // Digit storage: the longest digit string is 2^32 in binary
   localparam int MAX_DIGITS = 33;
   localparam int DIGIT_W    = 4;
   localparam int DIG_ADDR_W = $clog2(MAX_DIGITS);

   // Shared divider: bits retired per cycle and chunk count
   localparam int DIV_STEP    = 8;
   localparam int DIV_CHUNKS  = VALUE_W / DIV_STEP;
   localparam int CHUNK_IDX_W = $clog2(DIV_CHUNKS);

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_DEC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UPPER = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PTR   = 2'd3;

   // Prefix kinds
   localparam logic [1:0] PRE_NONE  = 2'd0;
   localparam logic [1:0] PRE_MINUS = 2'd1;
   localparam logic [1:0] PRE_HEX   = 2'd2;
   localparam logic [1:0] PRE_NIL   = 2'd3;

   // Radix limits and fixed bases
   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN  = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_N       = 8'h6E;
   localparam logic [CHAR_W-1:0] CHAR_I       = 8'h69;
   localparam logic [CHAR_W-1:0] CHAR_L       = 8'h6C;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN  = 8'h29;

   // Divider status toward the sequencer
   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] rem;
   } div_stat_type;

   // Number of prefix characters for a prefix kind
   function automatic logic [2:0] prefix_len(input logic [1:0] kind);
      logic [2:0] len;
      case (kind)
         PRE_NONE:  len = 3'd0;
         PRE_MINUS: len = 3'd1;
         PRE_HEX:   len = 3'd2;
         PRE_NIL:   len = 3'd5;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   // Prefix character at a given position
   function automatic logic [CHAR_W-1:0] prefix_char(input logic [1:0] kind,
                                                      input logic [2:0] idx);
      logic [CHAR_W-1:0] c;
      c = CHAR_MINUS;
      case (kind)
         PRE_HEX: c = (idx == 3'd0) ? CHAR_ZERO : CHAR_X;
         PRE_NIL: begin
            case (idx)
               3'd0:    c = CHAR_LPAREN;
               3'd1:    c = CHAR_N;
               3'd2:    c = CHAR_I;
               3'd3:    c = CHAR_L;
               default: c = CHAR_RPAREN;
            endcase
         end
         default: c = CHAR_MINUS;
      endcase
      return c;
   endfunction

   // Digit value to ASCII
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

   // Base used for a mode; radix saturates to 2..16
   function automatic logic [RADIX_W-1:0] eff_radix(input logic [MODE_W-1:0] mode,
                                                     input logic [RADIX_W-1:0] radix);
      logic [RADIX_W-1:0] r;
      case (mode)
         MODE_DEC: r = RADIX_DEC;
         MODE_PTR: r = RADIX_MAX;
         default: begin
            if (radix < RADIX_MIN) begin
               r = RADIX_MIN;
            end else if (radix > RADIX_MAX) begin
               r = RADIX_MAX;
            end else begin
               r = radix;
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/irta_if.sv -----
interface irta_req_if import irta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [VALUE_W-1:0] value;
   logic [RADIX_W-1:0] radix;

   modport source(output valid, mode, value, radix, input ready);
   modport sink(input valid, mode, value, radix, output ready);
endinterface

interface irta_rsp_if import irta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  char_code;
   logic               last;
   logic [COUNT_W-1:0] count;

   modport source(output valid, char_code, last, count, input ready);
   modport sink(input valid, char_code, last, count, output ready);
endinterface

// ----- rtl/core/irta_ram.sv -----
module irta_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/irta_divider.sv -----
module irta_divider import irta_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [RADIX_W-1:0] divisor,
   output logic [VALUE_W-1:0] quotient,
   output div_stat_type       stat
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CHUNK_IDX_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]     w_ff, w_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     dsr_ff, dsr_in;

   logic [CHUNK_IDX_W-1:0] top_chunk;
   logic [DIV_STEP-1:0]    chunk_cur;
   logic [DIV_STEP-1:0]    q_chunk;
   logic [DIGIT_W:0]       r_step;

   // Find the highest nonzero chunk so leading zero chunks are skipped
   always_comb begin
      top_chunk = '0;
      for (int b = 0; b < DIV_CHUNKS; b++) begin
         if (dividend[b*DIV_STEP +: DIV_STEP] != '0) begin
            top_chunk = CHUNK_IDX_W'(b);
         end
      end
   end

   // Retire one chunk of restoring long division per cycle
   always_comb begin
      chunk_cur = w_ff[DIV_STEP*cnt_ff +: DIV_STEP];
      r_step    = {1'b0, rem_ff};
      q_chunk   = '0;
      for (int j = DIV_STEP - 1; j >= 0; j--) begin
         r_step = {r_step[DIGIT_W-1:0], chunk_cur[j]};
         if (r_step >= dsr_ff) begin
            r_step     = r_step - dsr_ff;
            q_chunk[j] = 1'b1;
         end
      end
   end

   // Sequence the chunks from the top one down
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      w_in    = w_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         w_in    = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = top_chunk;
      end else if (busy_ff) begin
         w_in[DIV_STEP*cnt_ff +: DIV_STEP] = q_chunk;
         rem_in = r_step[DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      w_ff   <= w_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = w_ff;
   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;

endmodule

// ----- rtl/core/integer_radix_to_ascii.sv -----
// Operation: each digit is divided out in the shared divider, which works through the
// 8-bit chunks of the running magnitude from the highest nonzero one down (8 bits
// retired per cycle); then the prefix characters are emitted, then the digits, each
// digit through a registered digit-store read.
// One number at a time: a new number is taken only once the last character of the
// previous one has entered the output register and the sequencer is back in idle.
// Reset: synchronous, active high; clears the sequencer, divider and output valid.
module integer_radix_to_ascii import irta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   irta_req_if.sink    req,
   irta_rsp_if.source  rsp
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DSTART = 3'd1;
   localparam logic [2:0] ST_DWAIT  = 3'd2;
   localparam logic [2:0] ST_PRE    = 3'd3;
   localparam logic [2:0] ST_RD     = 3'd4;
   localparam logic [2:0] ST_PUT    = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         pre_kind_ff, pre_kind_in;
   logic               upper_ff, upper_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0] rad_ff, rad_in;
   logic [COUNT_W-1:0] ndig_ff, ndig_in;
   logic [2:0]         pre_idx_ff, pre_idx_in;
   logic [COUNT_W-1:0] pos_ff, pos_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               div_start;
   logic [VALUE_W-1:0] div_quot;
   div_stat_type       div_stat;

   logic                  wr_en;
   logic                  rd_en;
   logic [DIG_ADDR_W-1:0] wr_addr;
   logic [DIG_ADDR_W-1:0] rd_addr;
   logic [DIGIT_W-1:0]    rd_data;

   logic [32:0]        s33;
   logic [32:0]        mag33;
   logic               neg;
   logic               slot_free;
   logic               load;
   logic [CHAR_W-1:0]  load_char;
   logic [COUNT_W-1:0] pos_next;
   logic [COUNT_W-1:0] ndig_m1;
   logic [2:0]         pre_len;

   // Signed views of the incoming value
   assign s33   = (req.mode == MODE_DEC) ? {req.value[31], req.value[31:0]}
                                         : req.value[32:0];
   assign neg   = s33[32];
   assign mag33 = neg ? (~s33 + 33'd1) : s33;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pos_next  = pos_ff + 1'b1;
   assign ndig_m1   = ndig_ff - 1'b1;
   assign pre_len   = prefix_len(pre_kind_ff);
   assign wr_addr   = ndig_ff[DIG_ADDR_W-1:0];
   assign rd_addr   = ndig_m1[DIG_ADDR_W-1:0];

   // Sequencer: divide out digits, then emit prefix and digits
   always_comb begin
      state_in    = state_ff;
      pre_kind_in = pre_kind_ff;
      upper_in    = upper_ff;
      mag_in      = mag_ff;
      rad_in      = rad_ff;
      ndig_in     = ndig_ff;
      pre_idx_in  = pre_idx_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      div_start   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      load        = 1'b0;
      load_char   = CHAR_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               upper_in   = (req.mode == MODE_UPPER);
               rad_in     = eff_radix(req.mode, req.radix);
               ndig_in    = '0;
               pre_idx_in = '0;
               pos_in     = '0;
               if (req.mode == MODE_PTR) begin
                  mag_in      = req.value;
                  pre_kind_in = (req.value == '0) ? PRE_NIL : PRE_HEX;
               end else begin
                  mag_in      = {31'b0, mag33};
                  pre_kind_in = neg ? PRE_MINUS : PRE_NONE;
               end
               if (req.mode == MODE_PTR && req.value == '0) begin
                  total_in = COUNT_W'(prefix_len(PRE_NIL));
                  state_in = ST_PRE;
               end else begin
                  state_in = ST_DSTART;
               end
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               wr_en   = 1'b1;
               ndig_in = ndig_ff + 1'b1;
               mag_in  = div_quot;
               if (div_quot == '0) begin
                  total_in = {3'b0, pre_len} + ndig_ff + 1'b1;
                  state_in = (pre_kind_ff == PRE_NONE) ? ST_RD : ST_PRE;
               end else begin
                  state_in = ST_DSTART;
               end
            end
         end
         ST_PRE: begin
            if (slot_free) begin
               load       = 1'b1;
               load_char  = prefix_char(pre_kind_ff, pre_idx_ff);
               pre_idx_in = pre_idx_ff + 1'b1;
               pos_in     = pos_next;
               if (pre_idx_ff == pre_len - 1'b1) begin
                  state_in = (ndig_ff == '0) ? ST_IDLE : ST_RD;
               end
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (slot_free) begin
               load      = 1'b1;
               load_char = digit_char(rd_data, upper_ff);
               ndig_in   = ndig_m1;
               pos_in    = pos_next;
               state_in  = (ndig_ff == COUNT_W'(1)) ? ST_IDLE : ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: load a character or drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         char_in      = load_char;
         last_in      = (pos_next == total_ff);
         count_in     = (pos_next == total_ff) ? total_ff : '0;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pre_kind_ff <= pre_kind_in;
      upper_ff    <= upper_in;
      mag_ff      <= mag_in;
      rad_ff      <= rad_in;
      ndig_ff     <= ndig_in;
      pre_idx_ff  <= pre_idx_in;
      pos_ff      <= pos_in;
      total_ff    <= total_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      count_ff    <= count_in;
   end

   irta_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (rad_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   irta_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (div_stat.rem),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last      = last_ff;
   assign rsp.count     = count_ff;

endmodule

// ----- rtl/core/irta_checker.sv -----
module irta_checker import irta_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_last,
   input logic [COUNT_W-1:0] rsp_count
);

   // Hold a stalled character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Count shows only on the last character
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_count != '0)))
      else $error("count and last disagree");

   // Count stays within the longest string
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_count <= COUNT_W'(MAX_DIGITS + 1)))
      else $error("count exceeds maximum");

   // Block goes busy right after taking a number
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready stayed high after a transaction");

endmodule

bind integer_radix_to_ascii irta_checker u_irta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_last  (rsp.last),
   .rsp_count (rsp.count)
);

// ----- tb/sv/tb_integer_radix_to_ascii.sv -----
`timescale 1ns / 1ps

module tb_integer_radix_to_ascii;
   import irta_pkg::*;

   localparam int RANDOM_NUMBERS = 400;
   localparam int CYCLE_LIMIT    = 10_000_000;
   localparam int DRAIN_LIMIT    = 50_000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int HOLD_FROM      = 4000;
   localparam int HOLD_TO        = 4600;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
   } number_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  char_code;
      logic               last;
      logic [COUNT_W-1:0] count;
   } char_result_type;

   logic clock = 1'b0;
   logic reset;

   irta_req_if req_if ();
   irta_rsp_if rsp_if ();

   integer_radix_to_ascii u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   number_item_type pending_numbers[$];
   char_result_type expected_chars[$];
   int              numbers_total;
   int              numbers_accepted;
   int              mismatch_count;
   int              cycle_count;
   int              send_gap;
   int              send_calm;
   int              recv_stall;
   int              recv_calm;
   int              hold_count;
   logic            hold_off;

   // Free-running clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expand one number into the characters the formatter must produce
   function automatic void format_number(input number_item_type item);
      string           text;
      string           digits;
      string           tab;
      logic [63:0]     mag;
      logic [63:0]     base;
      logic [31:0]     v32;
      logic [32:0]     v33;
      logic            fixed_text;
      int              len;
      char_result_type r;
      text = "";
      digits = "";
      tab = "0123456789abcdef";
      base = 64'd10;
      mag = '0;
      fixed_text = 1'b0;
      case (item.mode)
         MODE_DEC: begin
            v32 = item.value[31:0];
            if (v32 == 32'h8000_0000) begin
               text = "-2147483648";
               fixed_text = 1'b1;
            end else begin
               mag = {32'b0, v32};
               if (v32[31]) begin
                  text = "-";
                  mag = 64'h1_0000_0000 - mag;
               end
            end
         end
         MODE_LOWER, MODE_UPPER: begin
            v33 = item.value[32:0];
            if (item.radix < RADIX_MIN) begin
               base = 64'(RADIX_MIN);
            end else if (item.radix > RADIX_MAX) begin
               base = 64'(RADIX_MAX);
            end else begin
               base = 64'(item.radix);
            end
            if (item.mode == MODE_UPPER) begin
               tab = "0123456789ABCDEF";
            end
            mag = {31'b0, v33};
            if (v33[32]) begin
               text = "-";
               mag = 64'h2_0000_0000 - mag;
            end
         end
         default: begin
            if (item.value == '0) begin
               text = "(nil)";
               fixed_text = 1'b1;
            end else begin
               text = "0x";
               mag = item.value;
               base = 64'd16;
            end
         end
      endcase
      // Peel digits off the low end, prepend so the most significant leads
      if (!fixed_text) begin
         do begin
            digits = {tab.substr(int'(mag % base), int'(mag % base)), digits};
            mag = mag / base;
         end while (mag != 0);
         text = {text, digits};
      end
      len = text.len();
      for (int i = 0; i < len; i++) begin
         r.char_code = text[i];
         r.last      = (i == len - 1);
         r.count     = (i == len - 1) ? COUNT_W'(len) : '0;
         expected_chars.push_back(r);
      end
   endfunction

   // Mostly short idles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 80);
   endfunction

   function automatic void add_number(input logic [MODE_W-1:0] mode,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix);
      number_item_type n;
      n.mode  = mode;
      n.value = value;
      n.radix = radix;
      pending_numbers.push_back(n);
   endfunction

   // Random number shaped toward sign edges, small magnitudes and saturation
   function automatic number_item_type random_number();
      number_item_type n;
      logic [32:0]     low;
      int              kind;
      n.mode  = MODE_W'($urandom_range(0, 3));
      n.radix = ($urandom_range(0, 7) == 0) ? RADIX_W'($urandom_range(0, 31))
                                            : RADIX_W'($urandom_range(2, 16));
      n.value = {$urandom, $urandom};
      kind = $urandom_range(0, 7);
      case (kind)
         3: n.value[32:0] = 33'($urandom_range(0, 20));
         4: begin
            low = 33'($urandom_range(1, 20));
            n.value[32:0] = -low;
         end
         5: begin
            case ($urandom_range(0, 5))
               0: n.value[32:0] = 33'h0_8000_0000;
               1: n.value[32:0] = 33'h0_7FFF_FFFF;
               2: n.value[32:0] = 33'h1_0000_0000;
               3: n.value[32:0] = 33'h0_FFFF_FFFF;
               4: n.value[32:0] = 33'h1_FFFF_FFFF;
               default: n.value = 64'd1 << $urandom_range(0, 63);
            endcase
         end
         6: n.value = ~(64'd1 << $urandom_range(0, 63));
         7: begin
            n.value[32:0] = '0;
            if ($urandom_range(0, 1) == 0) begin
               n.value = '0;
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   // Send numbers from the pending queue, predict on each accepted transaction
   always @(posedge clock) begin
      number_item_type n;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            n.mode  = req_if.mode;
            n.value = req_if.value;
            n.radix = req_if.radix;
            format_number(n);
            numbers_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_numbers.size() > 0) begin
               n = pending_numbers.pop_front();
               req_if.mode  <= n.mode;
               req_if.value <= n.value;
               req_if.radix <= n.radix;
               req_if.valid <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
               end else begin
                  send_gap = pick_gap();
                  if ($urandom_range(0, 29) == 0) begin
                     send_calm = $urandom_range(20, 60);
                  end
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         hold_off   <= 1'b0;
      end else begin
         hold_count <= hold_count + 1;
         hold_off   <= (hold_count >= HOLD_FROM) && (hold_count < HOLD_TO);
      end
   end

   // Drive result ready with random stalls and calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall = 0;
         recv_calm = 0;
      end else if (hold_off) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (recv_calm > 0) begin
            recv_calm--;
         end else begin
            if ($urandom_range(0, 5) == 0) begin
               recv_stall = pick_gap();
            end
            if ($urandom_range(0, 199) == 0) begin
               recv_calm = $urandom_range(50, 300);
            end
         end
      end
   end

   // Compare each accepted character against the oldest prediction
   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("[%0t] unexpected char: char=%h last=%b count=%0d", $realtime,
                        rsp_if.char_code, rsp_if.last, rsp_if.count);
            end
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_if.char_code !== want.char_code || rsp_if.last !== want.last ||
                rsp_if.count !== want.count) begin
               if (mismatch_count < 10) begin
                  $display("[%0t] char mismatch: exp %h/%b/%0d, got %h/%b/%0d",
                           $realtime, want.char_code, want.last, want.count,
                           rsp_if.char_code, rsp_if.last, rsp_if.count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode  = MODE_DEC;
      req_if.value = '0;
      req_if.radix = '0;
      rsp_if.ready = 1'b0;
      numbers_accepted = 0;
      mismatch_count = 0;
      cycle_count = 0;

      // Directed: sign edges, decimal minimum, radix saturation, null pointer
      add_number(MODE_DEC,   64'h0,                     5'd0);
      add_number(MODE_DEC,   64'h8000_0000,             5'd0);
      add_number(MODE_DEC,   64'h7FFF_FFFF,             5'd31);
      add_number(MODE_DEC,   64'hFFFF_FFFF,             5'd10);
      add_number(MODE_DEC,   64'h8000_0001,             5'd2);
      add_number(MODE_DEC,   64'hFFFF_FFFF_0000_0005,   5'd16);
      add_number(MODE_LOWER, 64'h1_0000_0000,           5'd2);
      add_number(MODE_LOWER, 64'h0_FFFF_FFFF,           5'd16);
      add_number(MODE_LOWER, 64'h0,                     5'd10);
      add_number(MODE_LOWER, 64'hABC,                   5'd0);
      add_number(MODE_LOWER, 64'h1234,                  5'd1);
      add_number(MODE_LOWER, 64'hFFFF_FFFF_FFFF_FFFF,   5'd31);
      add_number(MODE_LOWER, 64'hCAFE,                  5'd13);
      add_number(MODE_UPPER, 64'h0_DEAD_BEEF,           5'd16);
      add_number(MODE_UPPER, 64'h1_FFFF_FFFF,           5'd7);
      add_number(MODE_UPPER, 64'h1_0000_0000,           5'd16);
      add_number(MODE_UPPER, 64'h7FFF_FFFF,             5'd3);
      add_number(MODE_UPPER, 64'hFFFF_FFFE_0000_00FF,   5'd12);
      add_number(MODE_PTR,   64'h0,                     5'd0);
      add_number(MODE_PTR,   64'h1,                     5'd31);
      add_number(MODE_PTR,   64'hFFFF_FFFF_FFFF_FFFF,   5'd2);
      add_number(MODE_PTR,   64'h8000_0000_0000_0000,   5'd16);
      add_number(MODE_PTR,   64'h0000_0000_0000_0C00,   5'd10);

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         pending_numbers.push_back(random_number());
      end
      numbers_total = pending_numbers.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every number to be taken, then for its characters
      while (numbers_accepted < numbers_total) @(posedge clock);
      drain = 0;
      while (expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("[%0t] %0d predicted chars never arrived", $realtime, expected_chars.size());
         mismatch_count += expected_chars.size();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- integer_radix_to_ascii.f -----
rtl/core/irta_pkg.sv
rtl/core/irta_if.sv
rtl/core/irta_ram.sv
rtl/core/irta_divider.sv
rtl/core/integer_radix_to_ascii.sv
rtl/core/irta_checker.sv
tb/sv/tb_integer_radix_to_ascii.sv
